// ===== hw/rtl/aasr_pkg.sv =====
// shared types, command and status codes, message index lookup
`timescale 1ns / 1ps

package aasr_pkg;

  localparam int CodeWidth = 8;

  localparam logic [1:0] CMD_RAISE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SHOW  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ABSENT   = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  localparam logic [2:0] MSG_UNKNOWN = 3'd7;

  // broadcast to every cell
  typedef struct packed {
    logic                 raise_we;
    logic                 clear_en;
    logic [CodeWidth-1:0] code;
  } cell_ctrl_t;

  // rippled from cell to cell
  typedef struct packed {
    logic                 seen;
    logic [CodeWidth-1:0] rd_data;
  } cell_bus_t;

  function automatic logic [2:0] msg_index(input logic [CodeWidth-1:0] code);
    logic [2:0] idx;
    case (code)
      8'd9:    idx = 3'd0;
      8'd10:   idx = 3'd1;
      8'd14:   idx = 3'd2;
      8'd15:   idx = 3'd3;
      8'd23:   idx = 3'd4;
      8'd33:   idx = 3'd5;
      8'd99:   idx = 3'd6;
      default: idx = MSG_UNKNOWN;
    endcase
    return idx;
  endfunction

endpackage

// ===== hw/rtl/active_alarm_set_rotator_core.sv =====
// active alarm set with rotating display pointer, top level
//
//   channel  | dir | request contents (lsb first)
//   s_axis   | in  | tdata: cmd[1:0], alarm_code[9:2]
//   m_axis   | out | tdata: shown_code[7:0], message_index[10:8], has_alarm[11],
//            |     |        active_count[15:12], status[18:16]
//
// each request is registered first; then the cell row searches, shifts and
// updates in a single pass, once the output register is free or being read. a
// finished result waits in the output register while the next request is taken.
// reset empties all slots, zeroes count and pointer; no clearing pass. command 3 gives no result.
`timescale 1ns / 1ps

module active_alarm_set_rotator_core #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // cmd, alarm_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // shown_code, message_index, has_alarm,
                                        // active_count, status
);

  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int PW = $clog2(SLOT_COUNT);

  // request register
  logic                           item_valid_q;
  logic [1:0]                     cmd_q;
  logic [aasr_pkg::CodeWidth-1:0] code_q;

  // control state
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] ptr_q, ptr_d;

  // result register
  logic                           out_valid_q;
  logic [aasr_pkg::CodeWidth-1:0] shown_q, shown_d;
  logic [2:0]                     msg_q;
  logic                           has_q;
  logic [3:0]                     cnt_q;
  logic [2:0]                     status_q, status_d;

  logic                 exec;
  logic                 is_raise, is_clear, code_zero, found, full;
  logic                 raise_ok, clear_ok;
  logic [CW-1:0]        ptr_inc;
  aasr_pkg::cell_ctrl_t ctrl;

  aasr_pkg::cell_bus_t            bus [SLOT_COUNT+1];
  logic [aasr_pkg::CodeWidth-1:0] slot_w [SLOT_COUNT];

  assign s_axis_tready_o = !item_valid_q;
  assign exec            = item_valid_q && (!out_valid_q || m_axis_tready_i);

  assign is_raise  = (cmd_q == aasr_pkg::CMD_RAISE);
  assign is_clear  = (cmd_q == aasr_pkg::CMD_CLEAR);
  assign code_zero = (code_q == '0);
  assign found     = bus[SLOT_COUNT].seen;
  assign full      = (count_q == CW'(SLOT_COUNT));
  assign raise_ok  = is_raise && !code_zero && !found && !full;
  assign clear_ok  = is_clear && !code_zero && found;

  always_comb begin
    ctrl.raise_we = exec && raise_ok;
    ctrl.clear_en = exec && clear_ok;
    ctrl.code     = code_q;
  end

  assign bus[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic [aasr_pkg::CodeWidth-1:0] next_slot;
    if (i == SLOT_COUNT - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_mid
      assign next_slot = slot_w[i+1];
    end

    aasr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .wr_sel_i    (count_q == CW'(i)),
      .rd_sel_i    (ptr_q == PW'(i)),
      .next_slot_i (next_slot),
      .bus_i       (bus[i]),
      .bus_o       (bus[i+1]),
      .slot_o      (slot_w[i])
    );
  end

  assign ptr_inc = CW'(ptr_q) + CW'(1);

  always_comb begin
    count_d  = count_q;
    ptr_d    = ptr_q;
    shown_d  = code_q;
    status_d = aasr_pkg::ST_DONE;
    case (cmd_q)
      aasr_pkg::CMD_RAISE: begin
        if (code_zero) begin
          status_d = aasr_pkg::ST_ZERO;
        end else if (found) begin
          status_d = aasr_pkg::ST_DUP;
        end else if (full) begin
          status_d = aasr_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      aasr_pkg::CMD_CLEAR: begin
        if (code_zero) begin
          status_d = aasr_pkg::ST_ZERO;
        end else if (!found) begin
          status_d = aasr_pkg::ST_ABSENT;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      aasr_pkg::CMD_SHOW: begin
        if (count_q == '0) begin
          shown_d = '0;
        end else begin
          shown_d = bus[SLOT_COUNT].rd_data;
          ptr_d   = (ptr_inc < count_q) ? ptr_inc[PW-1:0] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      ptr_q        <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        item_valid_q <= 1'b1;
      end else if (exec) begin
        item_valid_q <= 1'b0;
      end
      if (exec && (cmd_q != aasr_pkg::CMD_NONE)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec) begin
        count_q <= count_d;
        ptr_q   <= ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q  <= s_axis_tdata_i[1:0];
      code_q <= s_axis_tdata_i[9:2];
    end
    if (exec && (cmd_q != aasr_pkg::CMD_NONE)) begin
      shown_q  <= shown_d;
      msg_q    <= aasr_pkg::msg_index(shown_d);
      has_q    <= (count_d != '0);
      cnt_q    <= 4'(count_d);
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, status_q, cnt_q, has_q, msg_q, shown_q};

endmodule

// ===== hw/rtl/aasr_cell.sv =====
// one alarm slot: match, read tap and shift-forward compaction
`timescale 1ns / 1ps

module aasr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aasr_pkg::cell_ctrl_t          ctrl_i,
  input  logic                          wr_sel_i,
  input  logic                          rd_sel_i,
  input  logic [aasr_pkg::CodeWidth-1:0] next_slot_i,
  input  aasr_pkg::cell_bus_t           bus_i,
  output aasr_pkg::cell_bus_t           bus_o,
  output logic [aasr_pkg::CodeWidth-1:0] slot_o
);

  logic [aasr_pkg::CodeWidth-1:0] slot_q, slot_d;
  logic                           hit;

  assign hit = (slot_q == ctrl_i.code) && (ctrl_i.code != '0);

  always_comb begin
    bus_o.seen    = bus_i.seen | hit;
    bus_o.rd_data = bus_i.rd_data | (rd_sel_i ? slot_q : '0);
  end

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.clear_en && bus_o.seen) begin
      slot_d = next_slot_i;
    end else if (ctrl_i.raise_we && wr_sel_i) begin
      slot_d = ctrl_i.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== hw/rtl/aasr_checker.sv =====
// port-level checks for the alarm set core, bound to the top level
`timescale 1ns / 1ps

module aasr_checker #(
  parameter int SLOT_COUNT = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  logic [3:0] cnt;
  logic [2:0] status;
  assign cnt    = m_axis_tdata_o[15:12];
  assign status = m_axis_tdata_o[18:16];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while one is pending");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (SLOT_COUNT >= 15) || (cnt <= 4'(SLOT_COUNT)))
    else $error("active count above slot count");

  a_has_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (SLOT_COUNT >= 15) || (m_axis_tdata_o[11] == (cnt != 4'd0)))
    else $error("has_alarm disagrees with count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status == aasr_pkg::ST_FULL) |-> cnt == 4'(SLOT_COUNT))
    else $error("full status with table not full");

endmodule

bind active_alarm_set_rotator_core aasr_checker #(.SLOT_COUNT(SLOT_COUNT)) u_aasr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/active_alarm_set_rotator_core_tb.sv =====
// testbench for the active alarm set rotator: directed and random commands checked by a scoreboard
`timescale 1ns / 1ps

module active_alarm_set_rotator_core_tb;

  localparam int SlotCount     = 8;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 795;
  localparam int DrainCycles   = 16;
  localparam int PressureHold  = 300;

  localparam logic [7:0] KnownCodes [7] = '{8'd9, 8'd10, 8'd14, 8'd15, 8'd23, 8'd33, 8'd99};
  localparam logic [7:0] CodePool [11] = '{8'd9, 8'd10, 8'd14, 8'd15, 8'd23, 8'd33, 8'd99,
                                          8'd1, 8'd128, 8'd200, 8'd255};

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] active_count;
    logic       has_alarm;
    logic [2:0] message_index;
    logic [7:0] shown_code;
  } alarm_result_t;

  class alarm_scoreboard;
    logic [7:0]    slots [SlotCount];
    int            active;
    int            pointer;
    alarm_result_t pending_results [$];
    int            errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      active  = 0;
      pointer = 0;
      errors  = 0;
    endfunction

    function logic [2:0] message_of(logic [7:0] code);
      foreach (KnownCodes[i]) begin
        if (KnownCodes[i] == code) return 3'(i);
      end
      return aasr_pkg::MSG_UNKNOWN;
    endfunction

    function int slot_of(logic [7:0] code);
      foreach (slots[i]) begin
        if (slots[i] == code) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] code);
      alarm_result_t r;
      int pos;
      r = '0;
      r.shown_code = code;
      r.status = aasr_pkg::ST_DONE;
      pos = slot_of(code);
      if (cmd == aasr_pkg::CMD_NONE) return;
      case (cmd)
        aasr_pkg::CMD_RAISE: begin
          if (code == 8'd0) r.status = aasr_pkg::ST_ZERO;
          else if (pos >= 0) r.status = aasr_pkg::ST_DUP;
          else if (active >= SlotCount) r.status = aasr_pkg::ST_FULL;
          else begin
            slots[active] = code;
            active++;
          end
        end
        aasr_pkg::CMD_CLEAR: begin
          if (code == 8'd0) r.status = aasr_pkg::ST_ZERO;
          else if (pos < 0) r.status = aasr_pkg::ST_ABSENT;
          else begin
            for (int i = pos; i + 1 < SlotCount; i++) slots[i] = slots[i + 1];
            slots[SlotCount - 1] = '0;
            if (active > 0) active--;
          end
        end
        default: begin
          if (active == 0) begin
            r.shown_code = '0;
          end else begin
            // stale pointer may sit past the active entries
            r.shown_code = slots[pointer];
            if (pointer + 1 < active) pointer++;
            else pointer = 0;
          end
        end
      endcase
      r.message_index = message_of(r.shown_code);
      r.has_alarm = (active != 0);
      r.active_count = 4'(active);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [23:0] data);
      alarm_result_t got, exp;
      got = data[18:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.shown_code != exp.shown_code) begin
        $display("%0t: shown_code expected %0d actual %0d", $time, exp.shown_code,
                 got.shown_code);
        errors++;
      end
      if (got.message_index != exp.message_index) begin
        $display("%0t: message_index expected %0d actual %0d", $time, exp.message_index,
                 got.message_index);
        errors++;
      end
      if (got.has_alarm != exp.has_alarm) begin
        $display("%0t: has_alarm expected %0d actual %0d", $time, exp.has_alarm,
                 got.has_alarm);
        errors++;
      end
      if (got.active_count != exp.active_count) begin
        $display("%0t: active_count expected %0d actual %0d", $time, exp.active_count,
                 got.active_count);
        errors++;
      end
      if (got.status != exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  alarm_scoreboard alarm_sb = new();
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit rx_pressure = 1'b0;
  int idle_cycles = 0;

  active_alarm_set_rotator_core #(.SLOT_COUNT(SlotCount)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request; valid stays high when the next one follows without a gap
  task automatic issue(input logic [1:0] cmd, input logic [7:0] code);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, code, cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    alarm_sb.note_request(cmd, code);
  endtask

  task automatic issue_random();
    int r;
    logic [1:0] cmd;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    if (r < 40) cmd = aasr_pkg::CMD_RAISE;
    else if (r < 65) cmd = aasr_pkg::CMD_CLEAR;
    else if (r < 95) cmd = aasr_pkg::CMD_SHOW;
    else cmd = aasr_pkg::CMD_NONE;
    if ($urandom_range(0, 99) < 85) code = CodePool[$urandom_range(0, 10)];
    else code = 8'($urandom_range(0, 255));
    issue(cmd, code);
  endtask

  always @(negedge clk_i) begin
    static int hold_left = 0;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_pressure) begin
      rx_pressure = 1'b0;
      hold_left = PressureHold;
      m_axis_tready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      hold_left = pick_gap();
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) alarm_sb.check_result(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, zero codes, absent clear
    issue(aasr_pkg::CMD_SHOW, 8'd0);
    issue(aasr_pkg::CMD_RAISE, 8'd0);
    issue(aasr_pkg::CMD_CLEAR, 8'd0);
    issue(aasr_pkg::CMD_CLEAR, 8'd5);
    foreach (KnownCodes[i]) issue(aasr_pkg::CMD_RAISE, KnownCodes[i]);
    issue(aasr_pkg::CMD_RAISE, 8'd255);
    // full table and duplicate
    issue(aasr_pkg::CMD_RAISE, 8'd1);
    issue(aasr_pkg::CMD_RAISE, 8'd9);
    // walk the pointer to the last slot, then shrink under it
    repeat (7) issue(aasr_pkg::CMD_SHOW, 8'd0);
    issue(aasr_pkg::CMD_CLEAR, 8'd10);
    issue(aasr_pkg::CMD_SHOW, 8'd170);
    issue(aasr_pkg::CMD_NONE, 8'd9);
    issue(aasr_pkg::CMD_CLEAR, 8'd255);

    sent = 0;
    while (sent < RandomItems) begin
      if (sent == 250) begin
        // burst against a stalled receiver
        tx_idle_en = 1'b0;
        rx_pressure = 1'b1;
        repeat (30) issue_random();
        tx_idle_en = 1'b1;
      end
      if (sent == 450) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (sent == 560) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      issue_random();
      sent++;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (alarm_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (alarm_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
